// ----- rtl/core/lcfb_pkg.sv -----
`default_nettype none

package lcfb_pkg;

  localparam int unsigned FrameMaxLen = 35;
  localparam int unsigned IdxW = 6;

  localparam logic [1:0] CMD_POWER  = 2'd0;
  localparam logic [1:0] CMD_LEVEL  = 2'd1;
  localparam logic [1:0] CMD_COLOUR = 2'd2;

  typedef enum logic [1:0] {
    KIND_POWER  = 2'd0,
    KIND_LEVEL  = 2'd1,
    KIND_COLOUR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] level;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } out_t;

  // frame descriptor handed from the front to the back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] b_a;
    logic [7:0] b_b;
  } desc_t;

  localparam logic [7:0] CSUM_BASE = 8'hFF;

  localparam logic [IdxW-1:0] IDX_CSUM_FIRST = 6'd3;
  localparam logic [IdxW-1:0] IDX_POWER      = 6'd25;
  localparam logic [IdxW-1:0] IDX_LEVEL      = 6'd26;
  localparam logic [IdxW-1:0] IDX_COL_XH     = 6'd26;
  localparam logic [IdxW-1:0] IDX_COL_X      = 6'd27;
  localparam logic [IdxW-1:0] IDX_COL_YH     = 6'd28;
  localparam logic [IdxW-1:0] IDX_COL_Y      = 6'd29;

  // templates, shorter frames padded with zeros
  localparam logic [7:0] TPL [3][FrameMaxLen] = '{
    '{8'h7E, 8'h00, 8'h19, 8'h11, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hE8, 8'h01, 8'h00, 8'h06, 8'h01,
      8'h04, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h10, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h00, 8'h1B, 8'h11, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hE8, 8'h01, 8'h00, 8'h08, 8'h01,
      8'h04, 8'h00, 8'h00, 8'h01, 8'h00, 8'h04, 8'h41, 8'h10, 8'h00, 8'h10,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h00, 8'h1F, 8'h11, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hE8, 8'h01, 8'h03, 8'h00, 8'h01,
      8'h04, 8'h00, 8'h00, 8'h01, 8'h00, 8'h07, 8'hAF, 8'h00, 8'hCF, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h10, 8'h00}
  };

  function automatic logic [IdxW-1:0] last_idx(input kind_e kind);
    logic [IdxW-1:0] r;
    case (kind)
      KIND_POWER:  r = 6'd28;
      KIND_LEVEL:  r = 6'd30;
      KIND_COLOUR: r = 6'd34;
      default:     r = 6'd28;
    endcase
    return r;
  endfunction

  // Q0.16 sRGB to XYZ matrix, row X/Y/Z, column R/G/B
  function automatic logic [15:0] coef(input logic [1:0] row, input logic [1:0] col);
    logic [15:0] r;
    case ({row, col})
      4'b0000: r = 16'd27026;
      4'b0001: r = 16'd23435;
      4'b0010: r = 16'd11826;
      4'b0100: r = 16'd13935;
      4'b0101: r = 16'd46870;
      4'b0110: r = 16'd4730;
      4'b1000: r = 16'd1267;
      4'b1001: r = 16'd7812;
      4'b1010: r = 16'd62284;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lcfb_front.sv -----
`default_nettype none

module lcfb_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire lcfb_pkg::in_t  in_data_i,
  output logic                busy_o,
  output logic                desc_valid_o,
  output lcfb_pkg::desc_t     desc_o,
  input  wire logic           desc_full_i
);

  localparam int unsigned AccW = 25;
  localparam int unsigned SumW = 26;
  localparam int unsigned NumW = 34;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MAC,
    F_SUM,
    F_DIV,
    F_PUSH
  } fstate_e;

  fstate_e         state_q;
  lcfb_pkg::desc_t desc_q;
  logic [7:0]      r_q, g_q, b_q;
  logic [1:0]      row_q, col_q;
  logic [AccW-1:0] ax_q, ay_q, az_q;
  logic [SumW-1:0] s_q;
  logic [NumW-1:0] nx_q, ny_q;
  logic [7:0]      qx_q, qy_q;
  logic [2:0]      i_q;

  logic [7:0]      ch;
  logic [23:0]     prod;
  logic [NumW-1:0] dsh;
  logic            ge_x, ge_y, s_zero;
  logic [7:0]      qx_fin, qy_fin;

  always_comb begin
    case (col_q)
      2'd0:    ch = r_q;
      2'd1:    ch = g_q;
      2'd2:    ch = b_q;
      default: ch = 8'd0;
    endcase
    prod   = lcfb_pkg::coef(row_q, col_q) * ch;
    dsh    = NumW'(s_q) << i_q;
    ge_x   = nx_q >= dsh;
    ge_y   = ny_q >= dsh;
    s_zero = s_q == '0;
    qx_fin = s_zero ? 8'd0 : {qx_q[6:0], ge_x};
    qy_fin = s_zero ? 8'd0 : {qy_q[6:0], ge_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            case (in_data_i.cmd)
              lcfb_pkg::CMD_POWER: begin
                desc_q  <= '{kind: lcfb_pkg::KIND_POWER,
                             b_a: {7'd0, in_data_i.level != 8'd0}, b_b: 8'd0};
                state_q <= F_PUSH;
              end
              lcfb_pkg::CMD_LEVEL: begin
                desc_q  <= '{kind: lcfb_pkg::KIND_LEVEL, b_a: in_data_i.level, b_b: 8'd0};
                state_q <= F_PUSH;
              end
              lcfb_pkg::CMD_COLOUR: begin
                r_q     <= in_data_i.red;
                g_q     <= in_data_i.green;
                b_q     <= in_data_i.blue;
                ax_q    <= '0;
                ay_q    <= '0;
                az_q    <= '0;
                row_q   <= 2'd0;
                col_q   <= 2'd0;
                state_q <= F_MAC;
              end
              default: ;
            endcase
          end
        end
        F_MAC: begin
          case (row_q)
            2'd0:    ax_q <= ax_q + AccW'(prod);
            2'd1:    ay_q <= ay_q + AccW'(prod);
            default: az_q <= az_q + AccW'(prod);
          endcase
          if (col_q == 2'd2) begin
            col_q <= 2'd0;
            row_q <= row_q + 2'd1;
            if (row_q == 2'd2) begin
              state_q <= F_SUM;
            end
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        F_SUM: begin
          s_q     <= SumW'(ax_q) + SumW'(ay_q) + SumW'(az_q);
          nx_q    <= (NumW'(ax_q) << 8) - NumW'(ax_q);
          ny_q    <= (NumW'(ay_q) << 8) - NumW'(ay_q);
          i_q     <= 3'd7;
          state_q <= F_DIV;
        end
        F_DIV: begin
          if (ge_x) begin
            nx_q <= nx_q - dsh;
          end
          if (ge_y) begin
            ny_q <= ny_q - dsh;
          end
          qx_q <= {qx_q[6:0], ge_x};
          qy_q <= {qy_q[6:0], ge_y};
          if (i_q == 3'd0) begin
            desc_q  <= '{kind: lcfb_pkg::KIND_COLOUR, b_a: qx_fin, b_b: qy_fin};
            state_q <= F_PUSH;
          end else begin
            i_q <= i_q - 3'd1;
          end
        end
        F_PUSH: begin
          if (!desc_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign busy_o       = state_q != F_IDLE;
  assign desc_valid_o = state_q == F_PUSH;
  assign desc_o       = desc_q;

endmodule

`default_nettype wire

// ----- rtl/core/lcfb_fifo.sv -----
`default_nettype none

module lcfb_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lcfb_pkg::desc_t  wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output lcfb_pkg::desc_t       rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcfb_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lcfb_back.sv -----
`default_nettype none

module lcfb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            desc_empty_i,
  input  wire lcfb_pkg::desc_t desc_i,
  output logic                 desc_pop_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output lcfb_pkg::out_t       out_o
);

  lcfb_pkg::desc_t            desc_q;
  logic                       busy_q;
  logic [lcfb_pkg::IdxW-1:0]  idx_q;
  logic [7:0]                 csum_q;
  logic                       ov_q;
  lcfb_pkg::out_t             out_q;

  logic [7:0] cur_byte;
  logic       is_last, pop_ok, adv, load;

  always_comb begin
    is_last  = idx_q == lcfb_pkg::last_idx(desc_q.kind);
    cur_byte = lcfb_pkg::TPL[desc_q.kind][idx_q];
    case (desc_q.kind)
      lcfb_pkg::KIND_POWER: begin
        if (idx_q == lcfb_pkg::IDX_POWER) cur_byte = desc_q.b_a;
      end
      lcfb_pkg::KIND_LEVEL: begin
        if (idx_q == lcfb_pkg::IDX_LEVEL) cur_byte = desc_q.b_a;
      end
      lcfb_pkg::KIND_COLOUR: begin
        if (idx_q == lcfb_pkg::IDX_COL_XH || idx_q == lcfb_pkg::IDX_COL_YH) begin
          cur_byte = 8'd0;
        end else if (idx_q == lcfb_pkg::IDX_COL_X) begin
          cur_byte = desc_q.b_a;
        end else if (idx_q == lcfb_pkg::IDX_COL_Y) begin
          cur_byte = desc_q.b_b;
        end
      end
      default: ;
    endcase
    if (is_last) cur_byte = lcfb_pkg::CSUM_BASE - csum_q;
  end

  assign pop_ok     = pop_i && ov_q;
  assign adv        = busy_q && (!ov_q || pop_ok);
  assign load       = !busy_q && !desc_empty_i;
  assign desc_pop_o = load;
  assign empty_o    = !ov_q;
  assign out_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (adv) begin
        out_q <= '{frame_byte: cur_byte, last: is_last};
        ov_q  <= 1'b1;
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 6'd1;
        end
        if (idx_q >= lcfb_pkg::IDX_CSUM_FIRST) begin
          csum_q <= csum_q + cur_byte;
        end
      end else if (pop_ok) begin
        ov_q <= 1'b0;
      end
      if (load) begin
        desc_q <= desc_i;
        busy_q <= 1'b1;
        idx_q  <= '0;
        csum_q <= 8'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/light_command_frame_builder.sv -----
`default_nettype none

// channel   direction  payload    transfer when
// command   in         in_t       push && !full
// frame     out        out_t      pop && !empty
//
// A colour command occupies the front for its transfer, 9 multiply-accumulate
// steps, one sum, 8 restoring divide steps for x and y together and one queue
// write. Power and brightness need only the transfer and the queue write. The
// back emits one byte per cycle while the output is popped; a frame is 29, 31
// or 35 bytes long. Reset clears all control state; no clearing pass.
// A stalled output holds the back; a full descriptor queue holds the front and then full.

module light_command_frame_builder #(
  parameter int unsigned DescDepth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  input  wire lcfb_pkg::in_t   in_data_i,
  output logic                 full,
  output logic                 empty,
  input  wire logic            pop,
  output lcfb_pkg::out_t       out_data_o
);

  logic            front_busy, desc_valid, desc_full, desc_empty, desc_pop;
  lcfb_pkg::desc_t desc_w, desc_r;

  assign full = front_busy;

  lcfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (push && !front_busy),
    .in_data_i    (in_data_i),
    .busy_o       (front_busy),
    .desc_valid_o (desc_valid),
    .desc_o       (desc_w),
    .desc_full_i  (desc_full)
  );

  lcfb_fifo #(
    .Depth (DescDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_valid),
    .wdata_i (desc_w),
    .full_o  (desc_full),
    .pop_i   (desc_pop),
    .empty_o (desc_empty),
    .rdata_o (desc_r)
  );

  lcfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_empty_i (desc_empty),
    .desc_i       (desc_r),
    .desc_pop_o   (desc_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_o        (out_data_o)
  );

endmodule

`default_nettype wire
